>>> sv/bcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants of the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int KEY_W     = 16;
  localparam int TIME_W    = 16;
  localparam int TICK_W    = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_KEYS  = 4;

  typedef enum logic [1:0] {
    OP_BUTTON     = 2'd0,
    OP_TICK       = 2'd1,
    OP_POWER_DOWN = 2'd2,
    OP_WAKE_UP    = 2'd3
  } opcode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONSUME = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG    = 3'd7;

  localparam logic [TICK_W-1:0] TICK_MS_RST   = 10'd100;
  localparam logic [TIME_W-1:0] SHORT_MAX_RST = 16'd500;
  localparam logic [TIME_W-1:0] LONG_MIN_RST  = 16'd5000;
  localparam logic [TIME_W-1:0] ELAPSED_MAX   = 16'hFFFF;

  localparam logic [1:0] CT_NONE   = 2'd0;
  localparam logic [1:0] CT_SHORT  = 2'd1;
  localparam logic [1:0] CT_LONG   = 2'd2;
  localparam logic [1:0] CT_DOUBLE = 2'd3;

  localparam logic KIND_CLICK   = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
    logic [1:0]       ctype;
    logic             consumed;
    logic             last;
  } result_t;

  typedef struct packed {
    logic load;
    logic step;
    logic phase;
    logic verdict;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic powered_off;
    logic pend_valid;
  } status_t;

  function automatic logic [1:0] classify(input logic [TIME_W-1:0] t,
                                          input logic [TIME_W-1:0] short_max,
                                          input logic [TIME_W-1:0] long_min);
    logic [1:0] c;
    c = CT_NONE;
    if (t < short_max) begin
      c = CT_SHORT;
    end else if (t > long_min) begin
      c = CT_LONG;
    end
    return c;
  endfunction

endpackage

>>> sv/button_click_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_classifier
// Sorts key presses of up to NUM_SLOTS watched keys into short, double, long
// and none clicks; ends every button word with a consume verdict.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    in_opcode, in_key_code, in_pressed
//   out      output     out_valid/out_ready  out_result_kind, out_click_key,
//                                            out_click_type, out_consumed, out_last
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Button word: accept, one step per slot, verdict, flush; tick word: accept,
// wait and press timer of each slot in turn through one shared update unit,
// then flush; power words: accept only. Powered off, a button word skips the
// slots and a tick word is accept only. A stalled output holds the steps; the
// next word is taken while the last result still sits in the output register.
// Reset is synchronous, active low; cfg_ready is always high.
// ----------------------------------------------------------------------------
module button_click_classifier #(
  parameter int NUM_SLOTS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_opcode,
  input  logic [bcc_pkg::KEY_W-1:0]     in_key_code,
  input  logic                          in_pressed,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_result_kind,
  output logic [bcc_pkg::KEY_W-1:0]     out_click_key,
  output logic [1:0]                    out_click_type,
  output logic                          out_consumed,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bcc_pkg::KEY_W-1:0]     cfg_data
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  bcc_pkg::cmd_t    cmd;
  bcc_pkg::status_t sts;
  bcc_pkg::result_t out_word;
  logic [SW-1:0]    slot;

  assign cfg_ready       = 1'b1;
  assign out_result_kind = out_word.kind;
  assign out_click_key   = out_word.key;
  assign out_click_type  = out_word.ctype;
  assign out_consumed    = out_word.consumed;
  assign out_last        = out_word.last;

  bcc_controller #(
    .NUM_SLOTS(NUM_SLOTS),
    .SW       (SW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_opcode(in_opcode),
    .sts      (sts),
    .cmd      (cmd),
    .slot     (slot)
  );

  bcc_datapath #(
    .NUM_SLOTS(NUM_SLOTS),
    .SW       (SW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .slot       (slot),
    .sts        (sts),
    .in_opcode  (in_opcode),
    .in_key_code(in_key_code),
    .in_pressed (in_pressed),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_word   (out_word)
  );

`ifndef SYNTH
  a_pend_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sts.pend_valid |-> !in_ready)
    else $error("pending result while idle");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.step, cmd.verdict, cmd.flush}))
    else $error("more than one command at once");

  a_cmd_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step || cmd.verdict || cmd.flush) |-> sts.out_free)
    else $error("command issued while output register is blocked");
`endif

endmodule

>>> sv/bcc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_datapath
// Configuration, per-slot timers, pending result and output word register.
// ----------------------------------------------------------------------------
module bcc_datapath #(
  parameter int NUM_SLOTS = 4,
  parameter int SW        = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bcc_pkg::cmd_t                   cmd,
  input  logic [SW-1:0]                   slot,
  output bcc_pkg::status_t                sts,
  input  logic [1:0]                      in_opcode,
  input  logic [bcc_pkg::KEY_W-1:0]       in_key_code,
  input  logic                            in_pressed,
  input  logic                            cfg_valid,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bcc_pkg::KEY_W-1:0]       cfg_data,
  input  logic                            out_ready,
  output logic                            out_valid,
  output bcc_pkg::result_t                out_word
);

  bcc_pkg::opcode_t                 op_r;
  logic [bcc_pkg::KEY_W-1:0]        key_r;
  logic                             down_r;
  logic                             cons_r;
  logic                             cons_nxt;

  logic [bcc_pkg::KEY_W-1:0]        key_cfg_r [NUM_SLOTS];
  logic [bcc_pkg::CFG_KEYS-1:0]     mask_r;
  logic [bcc_pkg::TICK_W-1:0]       tick_ms_r;
  logic [bcc_pkg::TIME_W-1:0]       short_max_r;
  logic [bcc_pkg::TIME_W-1:0]       long_min_r;
  logic [NUM_SLOTS-1:0]             cons_vec;

  logic                             press_run_r  [NUM_SLOTS];
  logic [bcc_pkg::TIME_W-1:0]       press_el_r   [NUM_SLOTS];
  logic                             wait_run_r   [NUM_SLOTS];
  logic [bcc_pkg::TIME_W-1:0]       wait_left_r  [NUM_SLOTS];
  logic                             powered_off_r;

  logic                             pr_nxt;
  logic [bcc_pkg::TIME_W-1:0]       el_nxt;
  logic                             wr_nxt;
  logic [bcc_pkg::TIME_W-1:0]       wl_nxt;

  logic [bcc_pkg::KEY_W-1:0]        s_key;
  logic [bcc_pkg::TIME_W-1:0]       s_el;
  logic [bcc_pkg::TIME_W-1:0]       s_wl;
  logic [bcc_pkg::TIME_W:0]         el_sum;
  logic [bcc_pkg::TIME_W-1:0]       el_sat;
  logic [bcc_pkg::TIME_W-1:0]       tick_ext;
  logic [1:0]                       rel_click;

  logic                             new_valid;
  bcc_pkg::result_t                 new_res;
  bcc_pkg::result_t                 pend_r;
  bcc_pkg::result_t                 pend_last;
  logic                             pend_valid_r;
  bcc_pkg::result_t                 out_r;
  logic                             out_valid_r;
  logic                             out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  assign sts.out_free    = out_free;
  assign sts.powered_off = powered_off_r;
  assign sts.pend_valid  = pend_valid_r;

  always_comb begin
    for (int j = 0; j < NUM_SLOTS; j++) begin
      cons_vec[j] = (j < bcc_pkg::CFG_KEYS) ? mask_r[j % bcc_pkg::CFG_KEYS] : 1'b0;
    end
  end

  assign s_key     = key_cfg_r[slot];
  assign s_el      = press_el_r[slot];
  assign s_wl      = wait_left_r[slot];
  assign tick_ext  = bcc_pkg::TIME_W'(tick_ms_r);
  assign el_sum    = {1'b0, s_el} + {1'b0, tick_ext};
  assign el_sat    = el_sum[bcc_pkg::TIME_W] ? bcc_pkg::ELAPSED_MAX
                                             : el_sum[bcc_pkg::TIME_W-1:0];
  assign rel_click = bcc_pkg::classify(s_el, short_max_r, long_min_r);

  always_comb begin
    pr_nxt    = press_run_r[slot];
    el_nxt    = s_el;
    wr_nxt    = wait_run_r[slot];
    wl_nxt    = s_wl;
    cons_nxt  = cons_r;
    new_valid = 1'b0;
    new_res   = '{kind: bcc_pkg::KIND_CLICK, key: s_key, ctype: bcc_pkg::CT_NONE,
                  consumed: 1'b0, last: 1'b0};
    if (cmd.step) begin
      if (op_r == bcc_pkg::OP_BUTTON) begin
        if (s_key == key_r) begin
          new_res.key = key_r;
          cons_nxt    = cons_vec[slot];
          if (down_r) begin
            pr_nxt = 1'b1;
            el_nxt = '0;
          end else if (press_run_r[slot]) begin
            if (rel_click != bcc_pkg::CT_SHORT) begin
              new_valid     = 1'b1;
              new_res.ctype = rel_click;
            end else if (wait_run_r[slot]) begin
              new_valid     = 1'b1;
              new_res.ctype = bcc_pkg::CT_DOUBLE;
              wr_nxt        = 1'b0;
              wl_nxt        = '0;
            end else begin
              wr_nxt = 1'b1;
              wl_nxt = short_max_r;
            end
            pr_nxt = 1'b0;
            el_nxt = '0;
          end
        end
      end else if (!cmd.phase) begin
        if (wait_run_r[slot]) begin
          if (s_wl <= tick_ext) begin
            new_valid     = 1'b1;
            new_res.ctype = bcc_pkg::CT_SHORT;
            wr_nxt        = 1'b0;
            wl_nxt        = '0;
          end else begin
            wl_nxt = s_wl - tick_ext;
          end
        end
      end else begin
        if (press_run_r[slot]) begin
          el_nxt = el_sat;
          if (bcc_pkg::classify(el_sat, short_max_r, long_min_r) == bcc_pkg::CT_LONG) begin
            new_valid     = 1'b1;
            new_res.ctype = bcc_pkg::CT_LONG;
            pr_nxt        = 1'b0;
            el_nxt        = '0;
          end
        end
      end
    end
    if (cmd.verdict) begin
      new_valid = 1'b1;
      new_res   = '{kind: bcc_pkg::KIND_VERDICT, key: key_r, ctype: bcc_pkg::CT_NONE,
                    consumed: cons_r, last: 1'b0};
    end
  end

  always_comb begin
    pend_last      = pend_r;
    pend_last.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r          <= bcc_pkg::OP_BUTTON;
      key_r         <= '0;
      down_r        <= 1'b0;
      cons_r        <= 1'b0;
      mask_r        <= '0;
      tick_ms_r     <= bcc_pkg::TICK_MS_RST;
      short_max_r   <= bcc_pkg::SHORT_MAX_RST;
      long_min_r    <= bcc_pkg::LONG_MIN_RST;
      powered_off_r <= 1'b0;
      pend_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
      for (int j = 0; j < NUM_SLOTS; j++) begin
        key_cfg_r[j]   <= '0;
        press_run_r[j] <= 1'b0;
        press_el_r[j]  <= '0;
        wait_run_r[j]  <= 1'b0;
        wait_left_r[j] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index) inside
          bcc_pkg::CFG_KEY_0, bcc_pkg::CFG_KEY_1,
          bcc_pkg::CFG_KEY_2, bcc_pkg::CFG_KEY_3: begin
            for (int j = 0; j < NUM_SLOTS; j++) begin
              if (j < bcc_pkg::CFG_KEYS && cfg_index == bcc_pkg::CFG_IDX_W'(j)) begin
                key_cfg_r[j] <= cfg_data;
              end
            end
          end
          bcc_pkg::CFG_CONSUME: mask_r      <= cfg_data[bcc_pkg::CFG_KEYS-1:0];
          bcc_pkg::CFG_TICK:    tick_ms_r   <= cfg_data[bcc_pkg::TICK_W-1:0];
          bcc_pkg::CFG_SHORT:   short_max_r <= cfg_data;
          bcc_pkg::CFG_LONG:    long_min_r  <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.load) begin
        op_r   <= bcc_pkg::opcode_t'(in_opcode);
        key_r  <= in_key_code;
        down_r <= in_pressed;
        cons_r <= 1'b0;
        if (bcc_pkg::opcode_t'(in_opcode) == bcc_pkg::OP_POWER_DOWN && !powered_off_r) begin
          powered_off_r <= 1'b1;
          for (int j = 0; j < NUM_SLOTS; j++) begin
            press_run_r[j] <= 1'b0;
            press_el_r[j]  <= '0;
            wait_run_r[j]  <= 1'b0;
            wait_left_r[j] <= '0;
          end
        end
        if (bcc_pkg::opcode_t'(in_opcode) == bcc_pkg::OP_WAKE_UP) begin
          powered_off_r <= 1'b0;
        end
      end

      if (cmd.step) begin
        press_run_r[slot] <= pr_nxt;
        press_el_r[slot]  <= el_nxt;
        wait_run_r[slot]  <= wr_nxt;
        wait_left_r[slot] <= wl_nxt;
        cons_r            <= cons_nxt;
      end

      out_valid_r <= (out_valid_r && !out_ready) ||
                     (pend_valid_r && (new_valid || cmd.flush));
      if (new_valid) begin
        pend_valid_r <= 1'b1;
      end
      if (cmd.flush && pend_valid_r) begin
        pend_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (new_valid) begin
      pend_r <= new_res;
      if (pend_valid_r) begin
        out_r <= pend_r;
      end
    end
    if (cmd.flush && pend_valid_r) begin
      out_r <= pend_last;
    end
  end

endmodule

>>> sv/bcc_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_controller
// Sequencer: walks the slots for button and tick words while powered on and schedules verdict and flush.
// ----------------------------------------------------------------------------
module bcc_controller #(
  parameter int NUM_SLOTS = 4,
  parameter int SW        = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_opcode,
  input  bcc_pkg::status_t sts,
  output bcc_pkg::cmd_t    cmd,
  output logic [SW-1:0]    slot
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BTN,
    S_TICK,
    S_VERDICT,
    S_FLUSH
  } state_t;

  state_t        state_r;
  state_t        state_nxt;
  logic [SW-1:0] slot_r;
  logic [SW-1:0] slot_nxt;
  logic          phase_r;
  logic          phase_nxt;
  logic          last_slot;

  assign last_slot = (slot_r == SW'(NUM_SLOTS - 1));
  assign in_ready  = (state_r == S_IDLE);
  assign slot      = slot_r;

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    phase_nxt = phase_r;
    cmd       = '0;
    cmd.phase = phase_r;
    unique case (state_r)
      S_IDLE: begin
        slot_nxt  = '0;
        phase_nxt = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (bcc_pkg::opcode_t'(in_opcode))
            bcc_pkg::OP_BUTTON: state_nxt = sts.powered_off ? S_VERDICT : S_BTN;
            bcc_pkg::OP_TICK:   state_nxt = sts.powered_off ? S_IDLE : S_TICK;
            default:            state_nxt = S_IDLE;
          endcase
        end
      end
      S_BTN: begin
        if (sts.out_free) begin
          cmd.step = 1'b1;
          slot_nxt = slot_r + SW'(1);
          if (last_slot) begin
            state_nxt = S_VERDICT;
          end
        end
      end
      S_TICK: begin
        if (sts.out_free) begin
          cmd.step  = 1'b1;
          phase_nxt = !phase_r;
          if (phase_r) begin
            slot_nxt = slot_r + SW'(1);
            if (last_slot) begin
              state_nxt = S_FLUSH;
            end
          end
        end
      end
      S_VERDICT: begin
        if (sts.out_free) begin
          cmd.verdict = 1'b1;
          state_nxt   = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      slot_r  <= '0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

>>> bench/tb_button_click_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_click_classifier
// Self-checking bench for the button click classifier. A scoreboard class
// keeps its own copy of the slot timers and registers, predicts the click
// reports and verdicts of every accepted word and checks each result word
// field by field. A short directed run is followed by random phases under
// several register settings, with random idling, a long output hold-off and
// a cycle watchdog.
// ----------------------------------------------------------------------------
module tb_button_click_classifier;
  import bcc_pkg::*;

  localparam int SLOTS       = CFG_KEYS;
  localparam int SETTLE_CYC  = 16;
  localparam int HOLD_CYC    = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int SPAN_CAP    = 70;

  class click_scoreboard;
    logic [KEY_W-1:0] keys[SLOTS];
    logic [3:0]       cmask;
    int               tick;
    int               shortmax;
    int               longmin;
    bit               press_on[SLOTS];
    int               press_t[SLOTS];
    bit               wait_on[SLOTS];
    int               wait_t[SLOTS];
    bit               asleep;
    result_t          pending[$];
    int               errors;

    function new();
      foreach (keys[i]) begin
        keys[i]     = '0;
        press_on[i] = 1'b0;
        press_t[i]  = 0;
        wait_on[i]  = 1'b0;
        wait_t[i]   = 0;
      end
      cmask    = '0;
      tick     = int'(TICK_MS_RST);
      shortmax = int'(SHORT_MAX_RST);
      longmin  = int'(LONG_MIN_RST);
      asleep   = 1'b0;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] v);
      case (idx)
        CFG_KEY_0, CFG_KEY_1, CFG_KEY_2, CFG_KEY_3: keys[idx] = v;
        CFG_CONSUME: cmask    = v[3:0];
        CFG_TICK:    tick     = int'(v[TICK_W-1:0]);
        CFG_SHORT:   shortmax = int'(v);
        CFG_LONG:    longmin  = int'(v);
        default: ;
      endcase
    endfunction

    function logic [1:0] grade_hold(int t);
      if (t < shortmax) return CT_SHORT;
      if (t > longmin) return CT_LONG;
      return CT_NONE;
    endfunction

    function result_t make_word(logic kind, logic [KEY_W-1:0] key, logic [1:0] ctype,
                                logic cons);
      result_t w;
      w.kind     = kind;
      w.key      = key;
      w.ctype    = ctype;
      w.consumed = cons;
      w.last     = 1'b0;
      return w;
    endfunction

    function void note_word(opcode_t op, logic [KEY_W-1:0] key, logic down);
      result_t    batch[$];
      logic       cons;
      logic [1:0] grade;
      int         t;
      cons = 1'b0;
      case (op)
        OP_BUTTON: begin
          if (!asleep) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (keys[i] == key) begin
                if (down) begin
                  press_t[i]  = 0;
                  press_on[i] = 1'b1;
                end else if (press_on[i]) begin
                  grade = grade_hold(press_t[i]);
                  if (grade != CT_SHORT) begin
                    batch.push_back(make_word(KIND_CLICK, key, grade, 1'b0));
                  end else if (wait_on[i]) begin
                    batch.push_back(make_word(KIND_CLICK, key, CT_DOUBLE, 1'b0));
                    wait_on[i] = 1'b0;
                    wait_t[i]  = 0;
                  end else begin
                    wait_on[i] = 1'b1;
                    wait_t[i]  = shortmax;
                  end
                  press_on[i] = 1'b0;
                  press_t[i]  = 0;
                end
                cons = cmask[i];
              end
            end
          end
          batch.push_back(make_word(KIND_VERDICT, key, CT_NONE, cons));
        end
        OP_TICK: begin
          if (!asleep) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (wait_on[i]) begin
                if (wait_t[i] <= tick) begin
                  batch.push_back(make_word(KIND_CLICK, keys[i], CT_SHORT, 1'b0));
                  wait_on[i] = 1'b0;
                  wait_t[i]  = 0;
                end else begin
                  wait_t[i] -= tick;
                end
              end
              if (press_on[i]) begin
                t = press_t[i] + tick;
                if (t > int'(ELAPSED_MAX)) t = int'(ELAPSED_MAX);
                press_t[i] = t;
                if (grade_hold(t) == CT_LONG) begin
                  press_on[i] = 1'b0;
                  press_t[i]  = 0;
                  batch.push_back(make_word(KIND_CLICK, keys[i], CT_LONG, 1'b0));
                end
              end
            end
          end
        end
        OP_POWER_DOWN: begin
          if (!asleep) begin
            for (int i = 0; i < SLOTS; i++) begin
              press_on[i] = 1'b0;
              press_t[i]  = 0;
              wait_on[i]  = 1'b0;
              wait_t[i]   = 0;
            end
            asleep = 1'b1;
          end
        end
        default: asleep = 1'b0;
      endcase
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) pending.push_back(batch[i]);
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result word: kind %0d key %h type %0d", got.kind, got.key,
               got.ctype);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind) begin
        $error("result_kind: expected %0d, actual %0d", want.kind, got.kind);
        errors++;
      end
      if (got.key !== want.key) begin
        $error("click_key: expected %h, actual %h", want.key, got.key);
        errors++;
      end
      if (got.ctype !== want.ctype) begin
        $error("click_type: expected %0d, actual %0d", want.ctype, got.ctype);
        errors++;
      end
      if (got.consumed !== want.consumed) begin
        $error("consumed: expected %0d, actual %0d", want.consumed, got.consumed);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_opcode = OP_TICK;
  logic [KEY_W-1:0]     in_key_code = '0;
  logic                 in_pressed = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_result_kind;
  logic [KEY_W-1:0]     out_click_key;
  logic [1:0]           out_click_type;
  logic                 out_consumed;
  logic                 out_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [KEY_W-1:0]     cfg_data = '0;

  click_scoreboard      sb;
  logic [KEY_W-1:0]     setup[8];
  int                   live = 0;
  bit                   steady = 1'b0;
  bit                   stall_req = 1'b0;

  button_click_classifier #(.NUM_SLOTS(SLOTS)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_key_code     (in_key_code),
    .in_pressed      (in_pressed),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_click_key   (out_click_key),
    .out_click_type  (out_click_type),
    .out_consumed    (out_consumed),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : result_side
    result_t got;
    int      hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.kind     = out_result_kind;
        got.key      = out_click_key;
        got.ctype    = out_click_type;
        got.consumed = out_consumed;
        got.last     = out_last;
        sb.check_word(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_req) begin
        stall_req = 1'b0;
        hold_left = HOLD_CYC;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 11);
      end
    end
  end

  task automatic send_word(opcode_t op, logic [KEY_W-1:0] key, logic down);
    if (!steady) begin
      while ($urandom_range(0, 99) < 11) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_key_code <= key;
    in_pressed  <= down;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if ((op == OP_BUTTON || op == OP_TICK) && !sb.asleep) live++;
    sb.note_word(op, key, down);
  endtask

  task automatic tick_words(int n);
    repeat (n) send_word(OP_TICK, 16'($urandom), 1'($urandom));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic load_setup();
    logic [CFG_IDX_W-1:0] idx;
    for (int i = 0; i < 8; i++) begin
      idx = i[CFG_IDX_W-1:0];
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= setup[idx];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(idx, setup[idx]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic plan_random();
    int r;
    int tk;
    int sh;
    int lg;
    for (int i = 0; i < SLOTS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 20 && i > 0) setup[CFG_KEY_0 + i] = setup[CFG_KEY_0 + i - 1];
      else if (r < 30) setup[CFG_KEY_0 + i] = 16'h0000;
      else if (r < 40) setup[CFG_KEY_0 + i] = 16'hFFFF;
      else setup[CFG_KEY_0 + i] = 16'($urandom);
    end
    tk = $urandom_range(1, 1000);
    sh = tk * $urandom_range(1, 5);
    lg = sh + tk * $urandom_range(0, 6);
    if (lg > 65534) lg = 65534;
    setup[CFG_CONSUME] = 16'($urandom_range(0, 15));
    setup[CFG_TICK]    = 16'(tk);
    setup[CFG_SHORT]   = 16'(sh);
    setup[CFG_LONG]    = 16'(lg);
  endtask

  function automatic int hold_span();
    int v;
    v = int'(setup[CFG_LONG]) / int'(setup[CFG_TICK]) + 3;
    return (v > SPAN_CAP) ? SPAN_CAP : v;
  endfunction

  task automatic run_random(int quota);
    int               goal;
    int               r;
    int               span;
    logic [KEY_W-1:0] k;
    goal = live + quota;
    span = hold_span();
    while (live < goal) begin
      r = $urandom_range(0, 99);
      k = setup[CFG_KEY_0 + $urandom_range(0, SLOTS - 1)];
      if (r < 70) begin
        send_word(OP_BUTTON, k, 1'b1);
        tick_words($urandom_range(0, span));
        send_word(OP_BUTTON, k, 1'b0);
        if ($urandom_range(0, 2) == 0) begin
          send_word(OP_BUTTON, k, 1'b1);
          tick_words($urandom_range(0, 1));
          send_word(OP_BUTTON, k, 1'b0);
        end
        tick_words($urandom_range(0, span));
      end else if (r < 76) begin
        send_word(OP_POWER_DOWN, 16'($urandom), 1'($urandom));
        send_word(OP_BUTTON, k, 1'($urandom));
        tick_words(1);
        send_word(OP_WAKE_UP, 16'($urandom), 1'($urandom));
      end else begin
        send_word(opcode_t'($urandom_range(0, 3)),
                  $urandom_range(0, 1) ? k : 16'($urandom), 1'($urandom));
      end
    end
    send_word(OP_WAKE_UP, 16'($urandom), 1'($urandom));
  endtask

  initial begin : stimulus
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    setup[CFG_KEY_0]   = 16'h0000;
    setup[CFG_KEY_1]   = 16'hFFFF;
    setup[CFG_KEY_2]   = 16'h1234;
    setup[CFG_KEY_3]   = 16'h1234;
    setup[CFG_CONSUME] = 16'h000A;
    setup[CFG_TICK]    = 16'd100;
    setup[CFG_SHORT]   = 16'd300;
    setup[CFG_LONG]    = 16'd400;
    load_setup();

    // short press then a second press inside the wait: double click
    send_word(OP_BUTTON, 16'hFFFF, 1'b1);
    tick_words(1);
    send_word(OP_BUTTON, 16'hFFFF, 1'b0);
    send_word(OP_BUTTON, 16'hFFFF, 1'b1);
    send_word(OP_BUTTON, 16'hFFFF, 1'b0);
    // wait runs out: short click
    send_word(OP_BUTTON, 16'h0000, 1'b1);
    send_word(OP_BUTTON, 16'h0000, 1'b0);
    tick_words(3);
    // two slots on one key held past the long limit
    send_word(OP_BUTTON, 16'h1234, 1'b1);
    tick_words(5);
    send_word(OP_BUTTON, 16'h1234, 1'b0);
    // release between the limits: none click
    send_word(OP_BUTTON, 16'hFFFF, 1'b1);
    tick_words(3);
    send_word(OP_BUTTON, 16'hFFFF, 1'b0);
    send_word(OP_BUTTON, 16'h5555, 1'b0);
    // powered off: keys and ticks ignored, repeated power words
    send_word(OP_POWER_DOWN, 16'h0000, 1'b0);
    send_word(OP_BUTTON, 16'hFFFF, 1'b1);
    tick_words(1);
    send_word(OP_POWER_DOWN, 16'hFFFF, 1'b1);
    send_word(OP_WAKE_UP, 16'h0000, 1'b0);
    send_word(OP_WAKE_UP, 16'hFFFF, 1'b1);
    settle();

    plan_random();
    setup[CFG_CONSUME] = 16'h000F;
    setup[CFG_TICK]    = 16'd1000;
    setup[CFG_SHORT]   = 16'd1000;
    setup[CFG_LONG]    = 16'd0;
    load_setup();
    run_random(34);
    settle();

    plan_random();
    setup[CFG_CONSUME] = 16'h0000;
    setup[CFG_TICK]    = 16'd1000;
    setup[CFG_SHORT]   = 16'd65535;
    setup[CFG_LONG]    = 16'd65534;
    load_setup();
    run_random(34);
    settle();

    steady = 1'b1;
    plan_random();
    setup[CFG_TICK]  = 16'd1;
    setup[CFG_SHORT] = 16'd3;
    setup[CFG_LONG]  = 16'd8;
    load_setup();
    run_random(34);
    settle();
    steady = 1'b0;

    plan_random();
    setup[CFG_TICK]  = 16'd7;
    setup[CFG_SHORT] = 16'd1;
    setup[CFG_LONG]  = 16'd20;
    load_setup();
    stall_req = 1'b1;
    run_random(34);

    for (int p = 0; p < 4; p++) begin
      settle();
      plan_random();
      load_setup();
      run_random(34);
    end

    settle();
    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> files.f
sv/bcc_pkg.sv
sv/bcc_datapath.sv
sv/bcc_controller.sv
sv/button_click_classifier.sv
bench/tb_button_click_classifier.sv
